[rtl/btnf_pkg.sv]
// btnf_pkg: shared types, constants and helper functions for the boundary tag allocator
// used by the arithmetic unit, the tag memory, the top level and its checker
// depends on nothing
package btnf_pkg;

	localparam int OFF_W   = 20;   // byte offsets and sizes with headroom for overflow checks
	localparam int TAG_W   = 19;   // stored tag: size with allocated flag in bit 0
	localparam int WADDR_W = 16;   // tag word index
	localparam int HEAP_WORDS = 1 << WADDR_W;

	localparam logic [OFF_W-1:0] HEAP_BYTES  = OFF_W'(HEAP_WORDS * 4);
	localparam logic [OFF_W-1:0] CHUNK_BYTES = OFF_W'(1 << 12);
	localparam logic [OFF_W-1:0] DSIZE       = OFF_W'(8);
	localparam logic [OFF_W-1:0] WSIZE       = OFF_W'(4);
	localparam logic [OFF_W-1:0] MIN_BLOCK   = OFF_W'(16);
	localparam logic [OFF_W-1:0] ROUND_ADD   = OFF_W'(15);
	localparam logic [OFF_W-1:0] FIRST_BP    = OFF_W'(8);
	localparam logic [OFF_W-1:0] FIRST_BLOCK = OFF_W'(16);
	localparam logic [OFF_W-1:0] RESET_END   = OFF_W'(16 + (1 << 12));

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_ZERO_SIZE = 2'd1;
	localparam logic [1:0] ST_NO_MEMORY = 2'd2;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam int INIT_COUNT = 5;
	localparam int INIT_W     = 3;

	typedef enum logic [0:0] {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [OFF_W-1:0] a;
		logic [OFF_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic               we;
		logic [WADDR_W-1:0] addr;
		logic [TAG_W-1:0]   wdata;
	} mem_req_t;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_ASIZE,
		S_RD_HDR,
		S_CHK,
		S_NEXT,
		S_PLACE,
		S_SPLIT,
		S_GROW,
		S_GROW2,
		S_GROW3,
		S_TAG_H,
		S_TAG_F1,
		S_TAG_F2,
		S_M1,
		S_M2,
		S_M3,
		S_M4,
		S_M5,
		S_M6,
		S_M7,
		S_F1,
		S_F2,
		S_ADONE,
		S_FDONE,
		S_OUT
	} state_t;

	// size field of a stored tag
	function automatic logic [OFF_W-1:0] tag_size(input logic [TAG_W-1:0] t);
		tag_size = {1'b0, t[TAG_W-1:3], 3'b000};
	endfunction

	// tag word written during the start-up sequence
	function automatic logic [WADDR_W-1:0] init_addr(input logic [INIT_W-1:0] i);
		case (i)
			3'd0:    init_addr = WADDR_W'(1);
			3'd1:    init_addr = WADDR_W'(2);
			3'd2:    init_addr = WADDR_W'(3);
			3'd3:    init_addr = WADDR_W'(1026);
			default: init_addr = WADDR_W'(1027);
		endcase
	endfunction

	function automatic logic [TAG_W-1:0] init_data(input logic [INIT_W-1:0] i);
		case (i)
			3'd0, 3'd1: init_data = TAG_W'(9);
			3'd2, 3'd3: init_data = TAG_W'(4096);
			default:    init_data = TAG_W'(1);
		endcase
	endfunction

endpackage

[rtl/btnf_alu.sv]
// btnf_alu: shared add / subtract unit with borrow flag
// every offset and size computation of the sequencer passes through here
// depends on btnf_pkg
module btnf_alu import btnf_pkg::*; (
	input  alu_req_t         req,
	output logic [OFF_W-1:0] y,
	output logic             lt
);

	logic [OFF_W:0] full;

	// one wide adder; lt is the borrow of a - b
	always_comb begin
		if (req.op == ALU_SUB) begin
			full = {1'b0, req.a} - {1'b0, req.b};
		end else begin
			full = {1'b0, req.a} + {1'b0, req.b};
		end
	end

	assign y  = full[OFF_W-1:0];
	assign lt = (req.op == ALU_SUB) && full[OFF_W];

endmodule

[rtl/btnf_mem.sv]
// btnf_mem: tag word store, one write and one registered read per cycle
// holds every header, footer, prologue and epilogue word of the arena
// depends on btnf_pkg
module btnf_mem import btnf_pkg::*; (
	input  logic             clk,
	input  mem_req_t         req,
	output logic [TAG_W-1:0] rdata
);

	logic [TAG_W-1:0] ram [HEAP_WORDS];

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			ram[req.addr] <= req.wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= ram[req.addr];
	end

endmodule

[rtl/boundary_tag_next_fit_allocator.sv]
// boundary_tag_next_fit_allocator: boundary tag heap with next-fit placement
// holds the sequencer; uses btnf_alu and btnf_mem, types from btnf_pkg
//
// Usage:
//   Input channel item_valid / item_stall carries action, request_bytes and
//   block_address. Output channel result_valid / result_stall carries
//   result_address and status; every item gives exactly one result.
//   An allocate walks the block tags from the rover, then places the block,
//   splitting it when the remainder is a whole block; when no block fits,
//   the heap grows and the new block is merged before placement.
//   A free walks the tags from the start of the heap to validate the
//   address, then marks and merges the block when it is allocated.
//   The steps run one after another on the single tag memory port and the single
//   shared adder. One item is in flight at a time: item_stall is high from
//   acceptance until its result has been taken.
//   After reset the block writes the prologue, the first 4096-byte free
//   block and the epilogue, with item_stall high. Words above the heap end
//   are never read, so no clearing pass is needed.
//   While result_stall is high the result holds and no new item is taken.
module boundary_tag_next_fit_allocator import btnf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        action,
	input  logic [18:0] request_bytes,
	input  logic [17:0] block_address,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [17:0] result_address,
	output logic [1:0]  status
);

	state_t state_q, state_d, ret_q, ret_d;

	logic [INIT_W-1:0] init_q, init_d;
	logic              action_q, action_d;
	logic [18:0]       req_q, req_d;
	logic [17:0]       addr_q, addr_d;
	logic [OFF_W-1:0]  bp_q, bp_d;
	logic [OFF_W-1:0]  asize_q, asize_d;
	logic [OFF_W-1:0]  size_q, size_d;
	logic [OFF_W-1:0]  rem_q, rem_d;
	logic [OFF_W-1:0]  tmp_q, tmp_d;
	logic [OFF_W-1:0]  tag_bp_q, tag_bp_d;
	logic [OFF_W-1:0]  tag_size_q, tag_size_d;
	logic              tag_a_q, tag_a_d;
	logic              pass_q, pass_d;
	logic [OFF_W-1:0]  heap_end_q, heap_end_d;
	logic [OFF_W-1:0]  rover_q, rover_d;
	logic [OFF_W-1:0]  new_end_q, new_end_d;
	logic              prev_alloc_q, prev_alloc_d;
	logic [OFF_W-1:0]  prev_size_q, prev_size_d;
	logic [OFF_W-1:0]  next_q, next_d;
	logic              next_alloc_q, next_alloc_d;
	logic [OFF_W-1:0]  next_size_q, next_size_d;
	logic [17:0]       res_q, res_d;
	logic [1:0]        status_q, status_d;

	alu_req_t         alu_req;
	logic [OFF_W-1:0] alu_y;
	logic             alu_lt;
	mem_req_t         mem_req;
	logic [TAG_W-1:0] rdata;
	logic [OFF_W-1:0] rd_size;

	btnf_alu u_alu (
		.req (alu_req),
		.y   (alu_y),
		.lt  (alu_lt)
	);

	btnf_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	assign rd_size = tag_size(rdata);

	// handshake and result ports
	assign item_stall     = (state_q != S_IDLE);
	assign result_valid   = (state_q == S_OUT);
	assign result_address = res_q;
	assign status         = status_q;

	// operands for the shared adder and the memory access of each state
	always_comb begin
		alu_req.op    = ALU_ADD;
		alu_req.a     = '0;
		alu_req.b     = '0;
		mem_req.we    = 1'b0;
		mem_req.addr  = alu_y[17:2];
		mem_req.wdata = '0;
		case (state_q)
			S_INIT: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = init_addr(init_q);
				mem_req.wdata = init_data(init_q);
			end
			S_ASIZE: begin
				alu_req.a = {1'b0, req_q};
				alu_req.b = ROUND_ADD;
			end
			S_RD_HDR, S_F1, S_M1: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = bp_q;
				alu_req.b  = WSIZE;
			end
			S_CHK: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = rd_size;
				alu_req.b  = asize_q;
			end
			S_NEXT: begin
				alu_req.a = bp_q;
				alu_req.b = size_q;
			end
			S_PLACE: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = size_q;
				alu_req.b  = asize_q;
			end
			S_SPLIT: begin
				alu_req.a = bp_q;
				alu_req.b = asize_q;
			end
			S_GROW: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = asize_q;
				alu_req.b  = CHUNK_BYTES;
			end
			S_GROW2: begin
				alu_req.a = heap_end_q;
				alu_req.b = tag_size_q;
			end
			S_GROW3: begin
				alu_req.op    = ALU_SUB;
				alu_req.a     = new_end_q;
				alu_req.b     = WSIZE;
				mem_req.we    = 1'b1;
				mem_req.wdata = TAG_W'(1);
			end
			S_TAG_H: begin
				alu_req.op    = ALU_SUB;
				alu_req.a     = tag_bp_q;
				alu_req.b     = WSIZE;
				mem_req.we    = 1'b1;
				mem_req.wdata = tag_size_q[TAG_W-1:0] | TAG_W'(tag_a_q);
			end
			S_TAG_F1: begin
				alu_req.a = tag_bp_q;
				alu_req.b = tag_size_q;
			end
			S_TAG_F2: begin
				alu_req.op    = ALU_SUB;
				alu_req.a     = tmp_q;
				alu_req.b     = DSIZE;
				mem_req.we    = 1'b1;
				mem_req.wdata = tag_size_q[TAG_W-1:0] | TAG_W'(tag_a_q);
			end
			S_M2: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = bp_q;
				alu_req.b  = DSIZE;
			end
			S_M3: begin
				alu_req.a = bp_q;
				alu_req.b = size_q;
			end
			S_M4: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = next_q;
				alu_req.b  = WSIZE;
			end
			S_M5: begin
				alu_req.a = size_q;
				alu_req.b = prev_size_q;
			end
			S_M6: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = bp_q;
				alu_req.b  = prev_size_q;
			end
			S_M7: begin
				alu_req.a = size_q;
				alu_req.b = next_size_q;
			end
			S_F2: begin
				alu_req.a = bp_q;
				alu_req.b = rd_size;
			end
			default: begin
			end
		endcase
	end

	// next state and datapath register updates
	always_comb begin
		state_d      = state_q;
		ret_d        = ret_q;
		init_d       = init_q;
		action_d     = action_q;
		req_d        = req_q;
		addr_d       = addr_q;
		bp_d         = bp_q;
		asize_d      = asize_q;
		size_d       = size_q;
		rem_d        = rem_q;
		tmp_d        = tmp_q;
		tag_bp_d     = tag_bp_q;
		tag_size_d   = tag_size_q;
		tag_a_d      = tag_a_q;
		pass_d       = pass_q;
		heap_end_d   = heap_end_q;
		rover_d      = rover_q;
		new_end_d    = new_end_q;
		prev_alloc_d = prev_alloc_q;
		prev_size_d  = prev_size_q;
		next_d       = next_q;
		next_alloc_d = next_alloc_q;
		next_size_d  = next_size_q;
		res_d        = res_q;
		status_d     = status_q;
		case (state_q)
			// start-up writes of the initial heap layout
			S_INIT: begin
				init_d = init_q + INIT_W'(1);
				if (init_q == INIT_W'(INIT_COUNT - 1)) begin
					state_d = S_IDLE;
				end
			end
			// take an item and dispatch
			S_IDLE: begin
				if (item_valid) begin
					action_d = action;
					req_d    = request_bytes;
					addr_d   = block_address;
					res_d    = '0;
					status_d = ST_OK;
					if (action == ACT_ALLOC) begin
						if (request_bytes == '0) begin
							status_d = ST_ZERO_SIZE;
							state_d  = S_OUT;
						end else begin
							state_d = S_ASIZE;
						end
					end else if (block_address == '0) begin
						state_d = S_OUT;
					end else begin
						bp_d    = FIRST_BLOCK;
						state_d = S_F1;
					end
				end
			end
			// round the request and start the search at the rover
			S_ASIZE: begin
				if (req_q <= 19'(DSIZE)) begin
					asize_d = MIN_BLOCK;
				end else begin
					asize_d = {alu_y[OFF_W-1:3], 3'b000};
				end
				bp_d    = rover_q;
				pass_d  = 1'b0;
				state_d = S_RD_HDR;
			end
			// second pass stops when it reaches the rover
			S_RD_HDR: begin
				if (pass_q && (bp_q == rover_q)) begin
					state_d = S_GROW;
				end else begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				size_d = rd_size;
				if (rd_size == '0) begin
					if (!pass_q) begin
						pass_d  = 1'b1;
						bp_d    = FIRST_BP;
						state_d = S_RD_HDR;
					end else begin
						state_d = S_GROW;
					end
				end else if (!rdata[0] && !alu_lt) begin
					state_d = S_PLACE;
				end else begin
					state_d = S_NEXT;
				end
			end
			S_NEXT: begin
				bp_d    = alu_y;
				state_d = S_RD_HDR;
			end
			// mark allocated, split when the remainder is a whole block
			S_PLACE: begin
				rem_d    = alu_y;
				tag_bp_d = bp_q;
				tag_a_d  = 1'b1;
				state_d  = S_TAG_H;
				if (alu_y >= MIN_BLOCK) begin
					tag_size_d = asize_q;
					ret_d      = S_SPLIT;
				end else begin
					tag_size_d = size_q;
					ret_d      = S_ADONE;
				end
			end
			S_SPLIT: begin
				tag_bp_d   = alu_y;
				tag_size_d = rem_q;
				tag_a_d    = 1'b0;
				ret_d      = S_ADONE;
				state_d    = S_TAG_H;
			end
			// growth size is the larger of request and chunk
			S_GROW: begin
				tag_size_d = alu_lt ? CHUNK_BYTES : asize_q;
				state_d    = S_GROW2;
			end
			S_GROW2: begin
				new_end_d = alu_y;
				if (alu_y > HEAP_BYTES) begin
					status_d = ST_NO_MEMORY;
					state_d  = S_OUT;
				end else begin
					tag_bp_d = heap_end_q;
					tag_a_d  = 1'b0;
					ret_d    = S_GROW3;
					state_d  = S_TAG_H;
				end
			end
			// new epilogue, then merge the new block
			S_GROW3: begin
				heap_end_d = new_end_q;
				bp_d       = heap_end_q;
				state_d    = S_M1;
			end
			// header and footer write sequence
			S_TAG_H: begin
				state_d = S_TAG_F1;
			end
			S_TAG_F1: begin
				tmp_d   = alu_y;
				state_d = S_TAG_F2;
			end
			S_TAG_F2: begin
				state_d = ret_q;
			end
			// merge with free neighbours
			S_M1: begin
				state_d = S_M2;
			end
			S_M2: begin
				size_d  = rd_size;
				state_d = S_M3;
			end
			S_M3: begin
				prev_alloc_d = rdata[0];
				prev_size_d  = rd_size;
				next_d       = alu_y;
				state_d      = S_M4;
			end
			S_M4: begin
				state_d = S_M5;
			end
			S_M5: begin
				next_alloc_d = rdata[0];
				next_size_d  = rd_size;
				if (!prev_alloc_q) begin
					size_d = alu_y;
				end
				state_d = S_M6;
			end
			S_M6: begin
				if (!prev_alloc_q) begin
					bp_d = alu_y;
				end
				state_d = S_M7;
			end
			S_M7: begin
				if (!next_alloc_q) begin
					size_d     = alu_y;
					tag_size_d = alu_y;
				end else begin
					tag_size_d = size_q;
				end
				tag_bp_d = bp_q;
				tag_a_d  = 1'b0;
				rover_d  = bp_q;
				ret_d    = (action_q == ACT_FREE) ? S_FDONE : S_PLACE;
				state_d  = S_TAG_H;
			end
			// free: walk the heap to validate the address
			S_F1: begin
				state_d = S_F2;
			end
			S_F2: begin
				if (rd_size == '0) begin
					state_d = S_FDONE;
				end else if (bp_q == {2'b00, addr_q}) begin
					if (rdata[0]) begin
						tag_bp_d   = bp_q;
						tag_size_d = rd_size;
						tag_a_d    = 1'b0;
						ret_d      = S_M1;
						state_d    = S_TAG_H;
					end else begin
						state_d = S_FDONE;
					end
				end else if (bp_q > {2'b00, addr_q}) begin
					state_d = S_FDONE;
				end else begin
					bp_d    = alu_y;
					state_d = S_F1;
				end
			end
			S_ADONE: begin
				res_d    = bp_q[17:0];
				status_d = ST_OK;
				state_d  = S_OUT;
			end
			S_FDONE: begin
				res_d    = '0;
				status_d = ST_OK;
				state_d  = S_OUT;
			end
			// hold the result until taken
			S_OUT: begin
				if (!result_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			init_q     <= '0;
			heap_end_q <= RESET_END;
			rover_q    <= FIRST_BLOCK;
		end else begin
			state_q    <= state_d;
			init_q     <= init_d;
			heap_end_q <= heap_end_d;
			rover_q    <= rover_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		ret_q        <= ret_d;
		action_q     <= action_d;
		req_q        <= req_d;
		addr_q       <= addr_d;
		bp_q         <= bp_d;
		asize_q      <= asize_d;
		size_q       <= size_d;
		rem_q        <= rem_d;
		tmp_q        <= tmp_d;
		tag_bp_q     <= tag_bp_d;
		tag_size_q   <= tag_size_d;
		tag_a_q      <= tag_a_d;
		pass_q       <= pass_d;
		new_end_q    <= new_end_d;
		prev_alloc_q <= prev_alloc_d;
		prev_size_q  <= prev_size_d;
		next_q       <= next_d;
		next_alloc_q <= next_alloc_d;
		next_size_q  <= next_size_d;
		res_q        <= res_d;
		status_q     <= status_d;
	end

endmodule

[rtl/btnf_checker.sv]
// btnf_checker: port-level checks for the boundary tag allocator
// bound to boundary_tag_next_fit_allocator; uses btnf_pkg status codes
module btnf_checker import btnf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        action,
	input logic [18:0] request_bytes,
	input logic [17:0] block_address,
	input logic        result_valid,
	input logic        result_stall,
	input logic [17:0] result_address,
	input logic [1:0]  status
);

	// a stalled input item stays offered and unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=>
			item_valid && $stable({action, request_bytes, block_address}))
		else $error("input item changed while stalled");

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// no new item while a result is pending
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> item_stall)
		else $error("item taken while result pending");

	// failures never return an address
	a_fail_null: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != ST_OK) |-> (result_address == '0))
		else $error("address returned with error status");

	// payload addresses are double-word aligned
	a_align: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_address[2:0] == 3'b000))
		else $error("misaligned payload address");

endmodule

bind boundary_tag_next_fit_allocator btnf_checker u_btnf_checker (.*);
